// ----- sv/fifo_queue_with_search_top_assert.svh -----
// Assertion macros shared by the queue-with-search RTL.
`ifndef FIFO_QUEUE_WITH_SEARCH_TOP_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define FQS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define FQS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define FQS_ASSERT(lbl, prop, msg)
`define FQS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- sv/fqs_pkg.sv -----
// Shared types, codes and constants of the queue-with-search block.
`default_nettype none

package fqs_pkg;

    // Default number of ring entries
    localparam int DEPTH_DEFAULT = 16;

    // Field widths fixed by the transfer formats
    localparam int DATA_W  = 32;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 11;

    // Opcodes
    localparam logic [2:0] OP_ENQUEUE = 3'd0;
    localparam logic [2:0] OP_DEQUEUE = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_FIND    = 3'd3;
    localparam logic [2:0] OP_WRITE   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef logic [COUNT_W-1:0] count_out_t;
    typedef logic [POS_W-1:0]   pos_t;

    // Request transfer
    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] value;
        pos_t                     position;
    } req_t;

    // Response transfer
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        count_out_t               found_position;
        logic                     is_empty;
        count_out_t               entry_count;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic start_read;
        logic start_scan;
        logic scan_step;
        logic capture;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_read;
        logic need_scan;
        logic hit;
        logic scan_end;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- sv/fqs_stream_if.sv -----
// Valid/ready stream interface with a typed payload.
`default_nettype none

interface fqs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/fqs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/fqs_ctrl.sv -----
// Sequencing state machine of the queue-with-search block.
`default_nettype none

`include "fifo_queue_with_search_top_assert.svh"

module fqs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire fqs_pkg::sts_t sts,
    output fqs_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.need_read)
                begin
                    cmd.start_read = 1'b1;
                    state_next     = S_WAIT;
                end
                else if (sts.need_scan)
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WAIT:
            begin
                cmd.capture = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN:
            begin
                // one compare per cycle, next read already in flight
                cmd.scan_step = 1'b1;
                if (sts.hit || sts.scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Checks
    `FQS_ASSERT(a_scan_follows_start, cmd.start_scan |=> cmd.scan_step, "scan did not start")
    `FQS_ASSERT(a_accept_then_busy, (req_valid && req_ready) |=> !req_ready, "accepted while busy")

endmodule

`default_nettype wire

// ----- sv/fqs_datapath.sv -----
// Ring pointers, entry store, search counter and response register.
`default_nettype none

`include "fifo_queue_with_search_top_assert.svh"

module fqs_datapath #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fqs_pkg::cmd_t cmd,
    output fqs_pkg::sts_t      sts,
    input  wire fqs_pkg::req_t in_payload,
    input  wire logic          out_ready,
    output logic               out_valid,
    output fqs_pkg::rsp_t      out_payload
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0] DEPTH_S = (IDX_W + 1)'(DEPTH);

    // Ring index of base plus offset, both below DEPTH
    function automatic logic [IDX_W-1:0] ring_slot(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] off
    );
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Latched request
    logic [2:0]                  op_reg;
    logic [fqs_pkg::DATA_W-1:0]  val_reg;
    fqs_pkg::pos_t               pos_reg;

    // Queue state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] oldest_reg;
    logic [IDX_W-1:0] oldest_next;

    // Search and read holding
    logic [IDX_W-1:0]           k_reg;
    logic                       hit_reg;
    fqs_pkg::count_out_t        found_reg;
    logic [fqs_pkg::DATA_W-1:0] rd_hold_reg;

    // Response register
    fqs_pkg::rsp_t out_reg;
    fqs_pkg::rsp_t rsp_next;
    logic          out_valid_reg;

    logic                       full;
    logic                       pos_ok;
    fqs_pkg::count_out_t        count_ext;
    fqs_pkg::pos_t              pos_m1;
    logic [CNT_W-1:0]           k_next_cnt;
    logic [IDX_W-1:0]           offset;
    logic [IDX_W-1:0]           slot;
    logic                       wr_ok;
    logic                       rd_en;
    logic [fqs_pkg::DATA_W-1:0] rd_data;

    // Request decode against current occupancy
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign count_ext  = fqs_pkg::count_out_t'(count_reg);
    assign pos_ok     = (pos_reg != '0) && ({1'b0, pos_reg} <= count_ext);
    assign pos_m1     = pos_reg - fqs_pkg::POS_W'(1);
    assign k_next_cnt = CNT_W'(k_reg) + CNT_W'(1);

    // One address path serves both RAM ports
    always_comb
    begin
        if (cmd.scan_step)
        begin
            offset = k_reg + IDX_W'(1);
        end
        else if (op_reg == fqs_pkg::OP_ENQUEUE)
        begin
            offset = count_reg[IDX_W-1:0];
        end
        else if (op_reg == fqs_pkg::OP_READ || op_reg == fqs_pkg::OP_WRITE)
        begin
            offset = pos_m1[IDX_W-1:0];
        end
        else
        begin
            offset = '0;
        end
    end

    assign slot  = ring_slot(oldest_reg, offset);
    assign rd_en = cmd.start_read | cmd.start_scan | cmd.scan_step;

    fqs_ram #(
        .WIDTH (fqs_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.commit & wr_ok),
        .wr_addr (slot),
        .wr_data (val_reg),
        .rd_en   (rd_en),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    // Status to controller
    always_comb
    begin
        sts.need_read = ((op_reg == fqs_pkg::OP_DEQUEUE) && (count_reg != '0))
                      || ((op_reg == fqs_pkg::OP_READ) && pos_ok);
        sts.need_scan = (op_reg == fqs_pkg::OP_FIND) && (count_reg != '0);
        sts.hit       = (rd_data == val_reg);
        sts.scan_end  = (k_next_cnt == count_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // Result and state update at commit
    always_comb
    begin
        rsp_next    = '0;
        count_next  = count_reg;
        oldest_next = oldest_reg;
        wr_ok       = 1'b0;
        case (op_reg)
            fqs_pkg::OP_ENQUEUE:
            begin
                if (full)
                begin
                    rsp_next.status = fqs_pkg::ST_FULL;
                end
                else
                begin
                    wr_ok      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            fqs_pkg::OP_DEQUEUE:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status = fqs_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp_next.read_value = rd_hold_reg;
                    oldest_next         = ring_slot(oldest_reg, IDX_W'(1));
                    count_next          = count_reg - CNT_W'(1);
                end
            end
            fqs_pkg::OP_READ:
            begin
                if (pos_ok)
                begin
                    rsp_next.read_value = rd_hold_reg;
                end
                else
                begin
                    rsp_next.status = fqs_pkg::ST_MISS;
                end
            end
            fqs_pkg::OP_FIND:
            begin
                if (hit_reg)
                begin
                    rsp_next.found_position = found_reg;
                end
                else
                begin
                    rsp_next.status = fqs_pkg::ST_MISS;
                end
            end
            fqs_pkg::OP_WRITE:
            begin
                if (pos_ok)
                begin
                    wr_ok = 1'b1;
                end
                else
                begin
                    rsp_next.status = fqs_pkg::ST_MISS;
                end
            end
            default:
            begin
                // unused opcodes leave everything alone
            end
        endcase
        rsp_next.is_empty    = (count_next == '0);
        rsp_next.entry_count = fqs_pkg::count_out_t'(count_next);
    end

    // Request, search and read holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg  <= in_payload.opcode;
            val_reg <= in_payload.value;
            pos_reg <= in_payload.position;
            hit_reg <= 1'b0;
        end
        if (cmd.start_scan)
        begin
            k_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            k_reg <= k_reg + IDX_W'(1);
            if (sts.hit)
            begin
                hit_reg   <= 1'b1;
                found_reg <= fqs_pkg::count_out_t'(k_next_cnt);
            end
        end
        if (cmd.capture)
        begin
            rd_hold_reg <= rd_data;
        end
        if (cmd.commit)
        begin
            out_reg <= rsp_next;
        end
    end

    // Queue pointers and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                oldest_reg    <= oldest_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_payload = out_reg;

    // Checks
    `FQS_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "count above depth")
    `FQS_ASSERT(a_oldest_bound, {1'b0, oldest_reg} < DEPTH_S, "oldest index out of ring")
    `FQS_ASSERT_NEVER(a_commit_blocked, cmd.commit && !sts.out_free, "response overwritten")
    `FQS_ASSERT(a_enq_count, (cmd.commit && op_reg == fqs_pkg::OP_ENQUEUE && !full) |=> count_reg == $past(count_reg) + CNT_W'(1), "enqueue count")

endmodule

`default_nettype wire

// ----- sv/fifo_queue_with_search_top.sv -----
// Bounded FIFO queue of signed words with positional access and search.
// Every request transfer yields one response transfer. Enqueue, overwrite,
// requests that fail on their own checks and unused opcodes go straight to
// commit; dequeue and read at position first pass through the registered
// read of the entry store; find walks the store one entry per cycle from the
// oldest until a match or the last entry. A new request is taken once the
// previous one has committed its response, even while that response still
// waits in the output register. No clearing pass runs after reset.
`default_nettype none

module fifo_queue_with_search_top #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
    input wire logic    clk,
    input wire logic    rst_n,
    fqs_stream_if.sink  req,
    fqs_stream_if.source rsp
);

    fqs_pkg::cmd_t cmd;
    fqs_pkg::sts_t sts;

    // Sequencer
    fqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Queue datapath
    fqs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_payload  (req.payload),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .out_payload (rsp.payload)
    );

endmodule

`default_nettype wire

// ----- sim/fifo_queue_with_search_top_tb.sv -----
// Self-checking testbench for the FIFO queue with positional access and search.
`timescale 1ns / 100ps

module fifo_queue_with_search_top_tb;

    import fqs_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int IDLE_PCT    = 35;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 2 * DEPTH + 10;
    localparam int RAND_ITEMS  = 1370;

    // Opcodes the block ignores
    localparam logic [2:0] OP_SPARE_MIN = 3'd5;
    localparam logic [2:0] OP_SPARE_MAX = 3'd7;

    localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam pos_t POS_TOP = {POS_W{1'b1}};

    typedef struct {
        req_t item;
        bit   drain_first;   // hold off until all replies are in
    } outgoing_t;

    logic clk = 1'b0;
    logic rst_n;

    fqs_stream_if #(.payload_t(req_t)) req_ch ();
    fqs_stream_if #(.payload_t(rsp_t)) rsp_ch ();

    fifo_queue_with_search_top #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    outgoing_t   requests_to_send[$];
    rsp_t        replies_due[$];
    int unsigned requests_taken = 0;
    int unsigned replies_seen   = 0;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;
    bit          req_taken      = 1'b0;

    // Queue shadow used for prediction
    logic signed [DATA_W-1:0] ring_word [DEPTH];
    int unsigned head_slot = 0;
    int unsigned fill      = 0;

    // One line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t reply %0d: %s", $realtime, replies_seen, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%08h expected 0x%08h", name, got, want));
    endtask

    // Advance the queue shadow by one request and return the reply it gives
    function automatic rsp_t apply_request(input req_t r);
        rsp_t        o;
        int unsigned k;
        bit          pos_ok;
        bit          hit;
        o        = '0;
        o.status = ST_OK;
        hit      = 1'b0;
        pos_ok   = (r.position >= 1) && (r.position <= fill);
        case (r.opcode)
            OP_ENQUEUE:
            begin
                if (fill >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    ring_word[(head_slot + fill) % DEPTH] = r.value;
                    fill++;
                end
            end
            OP_DEQUEUE:
            begin
                if (fill == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    o.read_value = ring_word[head_slot];
                    head_slot    = (head_slot + 1) % DEPTH;
                    fill--;
                end
            end
            OP_READ:
            begin
                if (pos_ok)
                    o.read_value = ring_word[(head_slot + r.position - 1) % DEPTH];
                else
                    o.status = ST_MISS;
            end
            OP_FIND:
            begin
                o.status = ST_MISS;
                for (k = 0; k < fill && !hit; k++)
                begin
                    if (ring_word[(head_slot + k) % DEPTH] == r.value)
                    begin
                        hit              = 1'b1;
                        o.found_position = count_out_t'(k + 1);
                        o.status         = ST_OK;
                    end
                end
            end
            OP_WRITE:
            begin
                if (pos_ok)
                    ring_word[(head_slot + r.position - 1) % DEPTH] = r.value;
                else
                    o.status = ST_MISS;
            end
            default: ;
        endcase
        o.is_empty    = (fill == 0);
        o.entry_count = count_out_t'(fill);
        return o;
    endfunction

    // No idling on either side for a stretch in the middle of the run
    function automatic bit side_idles();
        if (requests_taken >= 600 && requests_taken < 800)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // Driver: request side and reply back-pressure, changed at the falling edge
    always @(negedge clk)
    begin
        bit load;
        load = 1'b0;
        if (rst_n)
        begin
            if (!(req_ch.valid && !req_taken))
            begin
                if (requests_to_send.size() > 0 && !side_idles() &&
                    !(requests_to_send[0].drain_first && replies_due.size() > 0))
                    load = 1'b1;
                if (load)
                begin
                    req_ch.payload <= requests_to_send[0].item;
                    void'(requests_to_send.pop_front());
                end
                req_ch.valid <= load;
            end
            rsp_ch.ready <= !side_idles();
        end
    end

    // Monitor: predict on each request transfer, check each reply transfer
    always @(posedge clk)
    begin
        rsp_t want;
        bit   moved;
        if (rst_n)
        begin
            moved     = 1'b0;
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                replies_due.push_back(apply_request(req_ch.payload));
                requests_taken++;
                moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                if (replies_due.size() == 0)
                    report_mismatch("reply with no request outstanding");
                else
                begin
                    want = replies_due.pop_front();
                    check_field("status", 32'(rsp_ch.payload.status), 32'(want.status));
                    check_field("read_value", rsp_ch.payload.read_value, want.read_value);
                    check_field("found_position", 32'(rsp_ch.payload.found_position),
                                32'(want.found_position));
                    check_field("is_empty", 32'(rsp_ch.payload.is_empty),
                                32'(want.is_empty));
                    check_field("entry_count", 32'(rsp_ch.payload.entry_count),
                                32'(want.entry_count));
                end
                replies_seen++;
            end
            // Watchdog on cycles without any transfer
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic signed [DATA_W-1:0] gen_words[$];
        logic signed [DATA_W-1:0] val;
        logic [2:0]  op;
        pos_t        pos;
        int unsigned enq_pct;
        int unsigned counted;
        int unsigned total;
        int unsigned pick;
        int unsigned i;
        outgoing_t   o;

        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        rst_n          = 1'b0;

        // Directed: empty queue corner cases
        o.drain_first = 1'b0;
        o.item = '{OP_DEQUEUE, 0, 0};            requests_to_send.push_back(o);
        o.item = '{OP_READ, 0, 1};               requests_to_send.push_back(o);
        o.item = '{OP_FIND, 0, 0};               requests_to_send.push_back(o);
        o.item = '{OP_WRITE, WORD_MAX, POS_TOP}; requests_to_send.push_back(o);
        o.item = '{OP_SPARE_MIN, WORD_MIN, POS_TOP}; requests_to_send.push_back(o);
        // Fill to capacity, with a repeated word to check first match
        for (i = 0; i < DEPTH; i++)
        begin
            case (i)
                0:       val = WORD_MIN;
                1:       val = WORD_MAX;
                2:       val = 0;
                3, 10:   val = -1;
                default: val = $urandom;
            endcase
            o.item = '{OP_ENQUEUE, val, 0};
            requests_to_send.push_back(o);
        end
        // Full queue corner cases
        o.item = '{OP_ENQUEUE, 5, 0};                        requests_to_send.push_back(o);
        o.item = '{OP_READ, 0, 0};                           requests_to_send.push_back(o);
        o.item = '{OP_READ, 0, pos_t'(DEPTH)};               requests_to_send.push_back(o);
        o.item = '{OP_READ, 0, pos_t'(DEPTH + 1)};           requests_to_send.push_back(o);
        o.item = '{OP_FIND, -1, 0};                          requests_to_send.push_back(o);
        o.item = '{OP_FIND, 32'sh1234_5678, 0};              requests_to_send.push_back(o);
        o.item = '{OP_WRITE, 32'sh5a5a_a5a5, pos_t'(DEPTH)}; requests_to_send.push_back(o);
        o.item = '{OP_FIND, 32'sh5a5a_a5a5, 0};              requests_to_send.push_back(o);
        o.item = '{OP_WRITE, 0, POS_TOP};                    requests_to_send.push_back(o);
        o.item = '{OP_SPARE_MAX, -1, POS_TOP};               requests_to_send.push_back(o);
        o.item = '{OP_DEQUEUE, 0, 0};                        requests_to_send.push_back(o);
        o.item = '{OP_READ, 0, 1};                           requests_to_send.push_back(o);

        // Generator shadow after the directed part, only to aim positions and finds
        gen_words.delete();
        gen_words.push_back(WORD_MAX);
        gen_words.push_back(0);
        gen_words.push_back(-1);
        for (i = 4; i < DEPTH; i++)
            gen_words.push_back(0);

        // Random part: phases with a drifting enqueue bias sweep the fill level
        counted = 0;
        enq_pct = 50;
        while (counted < RAND_ITEMS)
        begin
            if (counted % 60 == 0)
            begin
                case ($urandom_range(3))
                    0:       enq_pct = 15;
                    1:       enq_pct = 35;
                    2:       enq_pct = 60;
                    default: enq_pct = 85;
                endcase
            end
            pick = $urandom_range(99);
            if (pick < enq_pct)
                op = OP_ENQUEUE;
            else if (pick >= 97)
                op = 3'($urandom_range(OP_SPARE_MAX, OP_SPARE_MIN));
            else
            begin
                case ($urandom_range(3))
                    0:       op = OP_DEQUEUE;
                    1:       op = OP_READ;
                    2:       op = OP_FIND;
                    default: op = OP_WRITE;
                endcase
            end
            // Word: small pool for duplicates, held word, extremes or anything
            pick = $urandom_range(99);
            if (pick < 30)
                val = $urandom_range(7);
            else if (pick < 50 && gen_words.size() > 0)
                val = gen_words[$urandom_range(gen_words.size() - 1)];
            else if (pick < 60)
                val = $urandom_range(1) ? WORD_MIN : WORD_MAX;
            else
                val = $urandom;
            // Position: mostly valid, some just past the end, zero or anything
            pick = $urandom_range(99);
            if (pick < 70 && gen_words.size() > 0)
                pos = pos_t'($urandom_range(gen_words.size(), 1));
            else if (pick < 80)
                pos = pos_t'(gen_words.size() + 1);
            else if (pick < 85)
                pos = 0;
            else
                pos = pos_t'($urandom);
            // Keep the generator shadow in step
            case (op)
                OP_ENQUEUE: if (gen_words.size() < DEPTH) gen_words.push_back(val);
                OP_DEQUEUE: if (gen_words.size() > 0) void'(gen_words.pop_front());
                OP_WRITE:   if (pos >= 1 && pos <= gen_words.size()) gen_words[pos - 1] = val;
                default: ;
            endcase
            o.item        = '{op, val, pos};
            o.drain_first = (counted == 0) || (counted == 700);
            requests_to_send.push_back(o);
            if (op <= OP_WRITE)
                counted++;
        end
        total = requests_to_send.size();

        // Reset, released on a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for all requests and their replies, then let the block settle
        while (requests_taken < total || replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/fqs_pkg.sv
sv/fqs_stream_if.sv
sv/fqs_ram.sv
sv/fqs_ctrl.sv
sv/fqs_datapath.sv
sv/fifo_queue_with_search_top.sv
sim/fifo_queue_with_search_top_tb.sv
